### hdl/hierarchical_timer_wheel_top_macros.svh
// Assertion helpers shared by the timer wheel RTL.
`ifndef HIERARCHICAL_TIMER_WHEEL_TOP_MACROS_SVH
`define HIERARCHICAL_TIMER_WHEEL_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HTW_ASSERT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("timer wheel assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define HTW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("timer wheel assertion failed");

`endif

### hdl/htw_pkg.sv
// ----------------------------------------------------------------------------
// htw_pkg
// Widths, day length and command codes of the timer wheel.
// ----------------------------------------------------------------------------
package htw_pkg;

  localparam int unsigned CmdW  = 2;
  localparam int unsigned IdW   = 6;
  localparam int unsigned TimeW = 17;

  localparam int unsigned SecsPerMin  = 60;
  localparam int unsigned MinsPerHour = 60;
  localparam int unsigned HoursPerDay = 24;
  localparam int unsigned DaySecondsI = SecsPerMin * MinsPerHour * HoursPerDay;
  localparam logic [TimeW-1:0] DaySeconds = TimeW'(DaySecondsI);

  // slots reachable through the id field
  localparam int unsigned NumIds = 2 ** IdW;

  localparam logic [CmdW-1:0] CmdTick   = 2'd0;
  localparam logic [CmdW-1:0] CmdAdd    = 2'd1;
  localparam logic [CmdW-1:0] CmdChange = 2'd2;
  localparam logic [CmdW-1:0] CmdDelete = 2'd3;

  typedef logic [TimeW-1:0] time_t;

endpackage

### hdl/htw_modadd.sv
// ----------------------------------------------------------------------------
// htw_modadd
// Shared add modulo one day: a + b, less one day if it reaches a day.
// Valid for a + b below two days.
// ----------------------------------------------------------------------------
module htw_modadd
  import htw_pkg::*;
(
  input  time_t a_i,
  input  time_t b_i,
  output time_t sum_o
);

  logic [TimeW:0] raw;
  logic [TimeW:0] red;

  assign raw   = {1'b0, a_i} + {1'b0, b_i};
  assign red   = raw - {1'b0, DaySeconds};
  assign sum_o = (raw >= {1'b0, DaySeconds}) ? red[TimeW-1:0] : raw[TimeW-1:0];

endmodule

### hdl/hierarchical_timer_wheel_top.sv
// ----------------------------------------------------------------------------
// hierarchical_timer_wheel_top
// 24-hour seconds clock with a set of timer slots, one deadline each.
// ----------------------------------------------------------------------------
// Use: one request on the input channel per command. Tick advances the
// clock one second (wrap at 86399) and then scans all slots in id order,
// sending one result per expired timer on the output channel; the final
// result of a tick carries last_o. Add, change and delete send nothing.
// Add and change pass through the reduce and place states; delete is
// done when it is accepted. A tick passes the tick state, then a read
// and a compare state per slot (N = NUM_TIMERS capped at 64 slots),
// then a flush state; in_ready_o is low meanwhile.
// Results go through one output register; a stalled receiver holds the
// scan at the next expiry until the register frees, nothing is dropped.
// An expiry is held back one step so last_o is known when it is sent.
// Reset clears the clock, all armed bits and the output register; the
// deadline memory is not cleared, a slot is only read while armed.
module hierarchical_timer_wheel_top
  import htw_pkg::*;
#(
  parameter int unsigned NUM_TIMERS = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [CmdW-1:0]  command_i,
  input  logic [IdW-1:0]   timer_id_i,
  input  logic [TimeW-1:0] offset_seconds_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [IdW-1:0]   expired_id_o,
  output logic [TimeW-1:0] fire_time_o,
  output logic             last_o
);

`include "hierarchical_timer_wheel_top_macros.svh"

  // slots above the id range can never be armed
  localparam int unsigned NSlot = (NUM_TIMERS < NumIds) ? NUM_TIMERS : NumIds;
  localparam int unsigned AW    = (NSlot > 1) ? $clog2(NSlot) : 1;
  localparam logic [AW-1:0] LastIdx = AW'(NSlot - 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_REDUCE = 3'd1;
  localparam logic [2:0] S_PLACE  = 3'd2;
  localparam logic [2:0] S_TICK   = 3'd3;
  localparam logic [2:0] S_SRD    = 3'd4;
  localparam logic [2:0] S_SCMP   = 3'd5;
  localparam logic [2:0] S_FLUSH  = 3'd6;

  logic [2:0]       state_q, state_d;
  logic [CmdW-1:0]  cmd_q, cmd_d;
  logic [AW-1:0]    id_q, id_d;
  time_t            off_q, off_d;
  time_t            clock_q, clock_d;
  logic [AW-1:0]    idx_q, idx_d;
  logic [NSlot-1:0] armed_q, armed_d;
  logic             pend_valid_q, pend_valid_d;
  logic [AW-1:0]    pend_id_q, pend_id_d;
  logic             out_valid_q, out_valid_d;
  logic [AW-1:0]    out_id_q, out_id_d;
  time_t            out_time_q, out_time_d;
  logic             out_last_q, out_last_d;

  time_t         mem [NSlot];
  time_t         rd_data_q;
  logic [AW-1:0] rd_addr;
  logic          mem_we;

  time_t op_a, op_b, sum;
  logic  in_acc, out_free, id_ok, hit;

  htw_modadd u_modadd (
    .a_i  (op_a),
    .b_i  (op_b),
    .sum_o(sum)
  );

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign id_ok      = (32'(timer_id_i) < NSlot);
  assign hit        = armed_q[idx_q] && (rd_data_q == clock_q);

  always_comb begin
    unique case (state_q)
      S_IDLE:            rd_addr = timer_id_i[AW-1:0];
      S_REDUCE, S_PLACE: rd_addr = id_q;
      default:           rd_addr = idx_q;
    endcase
  end

  // operand select for the shared modulo-day adder
  always_comb begin
    unique case (state_q)
      S_REDUCE: begin
        op_a = off_q;
        op_b = '0;
      end
      S_PLACE: begin
        op_a = (cmd_q == CmdChange) ? rd_data_q : clock_q;
        op_b = off_q;
      end
      S_TICK: begin
        op_a = clock_q;
        op_b = TimeW'(1);
      end
      default: begin
        op_a = clock_q;
        op_b = '0;
      end
    endcase
  end

  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    id_d         = id_q;
    off_d        = off_q;
    clock_d      = clock_q;
    idx_d        = idx_q;
    armed_d      = armed_q;
    pend_valid_d = pend_valid_q;
    pend_id_d    = pend_id_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_id_d     = out_id_q;
    out_time_d   = out_time_q;
    out_last_d   = out_last_q;
    mem_we       = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          cmd_d = command_i;
          id_d  = timer_id_i[AW-1:0];
          off_d = offset_seconds_i;
          priority if (command_i == CmdTick) begin
            state_d = S_TICK;
          end else if (!id_ok) begin
            state_d = S_IDLE;
          end else if (command_i == CmdDelete) begin
            armed_d[timer_id_i[AW-1:0]] = 1'b0;
          end else begin
            state_d = S_REDUCE;
          end
        end
      end
      S_REDUCE: begin
        off_d   = sum;
        state_d = S_PLACE;
      end
      S_PLACE: begin
        // change on a disarmed slot does nothing
        if (cmd_q == CmdAdd || armed_q[id_q]) begin
          mem_we        = 1'b1;
          armed_d[id_q] = (sum != clock_q);
        end
        state_d = S_IDLE;
      end
      S_TICK: begin
        clock_d = sum;
        idx_d   = '0;
        state_d = S_SRD;
      end
      S_SRD: begin
        state_d = S_SCMP;
      end
      S_SCMP: begin
        if (hit && pend_valid_q && !out_free) begin
          state_d = S_SCMP;
        end else begin
          if (hit) begin
            if (pend_valid_q) begin
              out_valid_d = 1'b1;
              out_id_d    = pend_id_q;
              out_time_d  = clock_q;
              out_last_d  = 1'b0;
            end
            pend_valid_d   = 1'b1;
            pend_id_d      = idx_q;
            armed_d[idx_q] = 1'b0;
          end
          if (idx_q == LastIdx) begin
            state_d = S_FLUSH;
          end else begin
            idx_d   = idx_q + AW'(1);
            state_d = S_SRD;
          end
        end
      end
      S_FLUSH: begin
        if (!pend_valid_q) begin
          state_d = S_IDLE;
        end else if (out_free) begin
          out_valid_d  = 1'b1;
          out_id_d     = pend_id_q;
          out_time_d   = clock_q;
          out_last_d   = 1'b1;
          pend_valid_d = 1'b0;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      clock_q      <= '0;
      armed_q      <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      clock_q      <= clock_d;
      armed_q      <= armed_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    id_q       <= id_d;
    off_q      <= off_d;
    idx_q      <= idx_d;
    pend_id_q  <= pend_id_d;
    out_id_q   <= out_id_d;
    out_time_q <= out_time_d;
    out_last_q <= out_last_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[id_q] <= sum;
    end
    rd_data_q <= mem[rd_addr];
  end

  assign out_valid_o  = out_valid_q;
  assign expired_id_o = IdW'(out_id_q);
  assign fire_time_o  = out_time_q;
  assign last_o       = out_last_q;

  `HTW_ASSERT(a_clock_range, clk_i, rst_ni, 1'b1, clock_q < DaySeconds)
  `HTW_ASSERT(a_no_pend_idle, clk_i, rst_ni, state_q == S_IDLE, !pend_valid_q)
  `HTW_ASSERT_NEXT(a_tick_step, clk_i, rst_ni, state_q == S_TICK,
    clock_q == (($past(clock_q) == DaySeconds - TimeW'(1)) ? '0 : $past(clock_q) + TimeW'(1)))

endmodule
